// File: design/ffbs_pkg.sv
// Package for the first-fit burst scheduler: status codes, opcodes,
// register indexes and the structs shared between the modules.
// No dependencies.
package ffbs_pkg;

  localparam int TAG_W   = 16;
  localparam int BURST_W = 16;
  localparam int TOTAL_W = 24;
  localparam int CAP_W   = 25;
  localparam int WIN_W   = 7;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_SELECT  = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_WINDOW   = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_SELECTED = 2'd2,
    ST_NONE     = 2'd3
  } ffbs_status_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic [WIN_W-1:0] window;
  } ffbs_cfg_t;

  // broadcast to every cell for the fit check
  typedef struct packed {
    logic               eval;
    logic [TOTAL_W-1:0] exec_total;
    logic [CAP_W-1:0]   capacity;
    logic [WIN_W-1:0]   window;
  } ffbs_bcast_t;

endpackage

// File: design/ffbs_if.sv
// Channel interfaces for the scheduler: request words in, result words out.
// Depends on ffbs_pkg for field widths.
interface ffbs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [ffbs_pkg::TAG_W-1:0]   req_tag;
  logic [ffbs_pkg::BURST_W-1:0] req_burst;
  logic [ffbs_pkg::TOTAL_W-1:0] executing_total;

  modport source (output valid, opcode, req_tag, req_burst, executing_total, input ready);
  modport sink (input valid, opcode, req_tag, req_burst, executing_total, output ready);
endinterface

interface ffbs_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [ffbs_pkg::TAG_W-1:0]   sel_tag;
  logic [ffbs_pkg::BURST_W-1:0] sel_burst;

  modport source (output valid, status, sel_tag, sel_burst, input ready);
  modport sink (input valid, status, sel_tag, sel_burst, output ready);
endinterface

// File: design/ffbs_cfg.sv
// APB register block: execution capacity and search window.
// Depends on ffbs_pkg.
module ffbs_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffbs_pkg::APB_AW-1:0]   paddr,
  input  logic [ffbs_pkg::APB_DW-1:0]   pwdata,
  output logic [ffbs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output ffbs_pkg::ffbs_cfg_t           cfg
);
  import ffbs_pkg::*;

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic [WIN_W-1:0] win_r, win_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cap_nxt = cap_r;
    win_nxt = win_r;
    if (wr_en) begin
      if (paddr[2] == REG_CAPACITY) begin
        cap_nxt = pwdata[CAP_W-1:0];
      end else begin
        win_nxt = pwdata[WIN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '1;
      win_r <= '0;
    end else begin
      cap_r <= cap_nxt;
      win_r <= win_nxt;
    end
  end

  always_comb begin
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(APB_DW-CAP_W){cap_r[CAP_W-1]}}, cap_r};
    end else begin
      prdata = {{(APB_DW-WIN_W){1'b0}}, win_r};
    end
  end

  assign cfg.capacity = cap_r;
  assign cfg.window   = win_r;

endmodule

// File: design/ffbs_cell.sv
// One queue slot: holds a tag and burst, checks its own fit and shifts
// towards the head when an older entry is removed. Depends on ffbs_pkg.
module ffbs_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                          clk,
  input  logic                          load_en,
  input  logic [ffbs_pkg::TAG_W-1:0]    load_tag,
  input  logic [ffbs_pkg::BURST_W-1:0]  load_burst,
  input  logic                          shift_en,
  input  logic [ffbs_pkg::TAG_W-1:0]    nxt_tag,
  input  logic [ffbs_pkg::BURST_W-1:0]  nxt_burst,
  input  ffbs_pkg::ffbs_bcast_t         bcast,
  input  logic [CW-1:0]                 count,
  output logic [ffbs_pkg::TAG_W-1:0]    tag,
  output logic [ffbs_pkg::BURST_W-1:0]  burst,
  output logic                          hit
);
  import ffbs_pkg::*;

  localparam logic             IDX_SMALL = (IDX < (1 << WIN_W));
  localparam logic [WIN_W-1:0] IDX_W     = WIN_W'(IDX % (1 << WIN_W));
  localparam logic [CW-1:0]    IDX_C     = CW'(IDX);

  logic [TAG_W-1:0]   tag_r;
  logic [BURST_W-1:0] burst_r;
  logic               hit_r;
  logic [CAP_W-1:0]   sum;
  logic               unlimited, fit, occupied, in_win, hit_nxt;

  always_comb begin
    unlimited = bcast.capacity[CAP_W-1];
    sum       = {{(CAP_W-BURST_W){1'b0}}, burst_r} + {1'b0, bcast.exec_total};
    fit       = unlimited || (sum <= {1'b0, bcast.capacity[CAP_W-2:0]});
    occupied  = count > IDX_C;
    // window of zero searches everything
    in_win    = unlimited || (bcast.window == '0) || (IDX_SMALL && (bcast.window > IDX_W));
    hit_nxt   = occupied && fit && in_win;
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      tag_r   <= load_tag;
      burst_r <= load_burst;
    end else if (shift_en) begin
      tag_r   <= nxt_tag;
      burst_r <= nxt_burst;
    end
    if (bcast.eval) begin
      hit_r <= hit_nxt;
    end
  end

  assign tag   = tag_r;
  assign burst = burst_r;
  assign hit   = hit_r;

endmodule

// File: design/first_fit_burst_scheduler.sv
// Top level of the first-fit burst scheduler: row of queue cells, first-hit
// pick, removal shift and output register. Depends on ffbs_pkg, ffbs_if,
// ffbs_cfg and ffbs_cell.
//
//  port    dir   kind       contents
//  in_if   in    valid/rdy  opcode, req_tag, req_burst, executing_total
//  out_if  out   valid/rdy  status, sel_tag, sel_burst
//  psel..  in    APB        exec_capacity @0x0, search_window @0x4
//
// Per word: the accept edge writes the new entry or latches every cell's fit bit;
// with the output register free, a later edge picks the lowest hit, shifts the
// cells above it one place towards the head and loads the output register.
// A new word is taken once the previous result has moved into the output
// register, so a waiting result stalls input only after a second word.
// Reset (rst_n, synchronous) empties the queue; no clearing pass is needed.
module first_fit_burst_scheduler #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ffbs_in_if.sink                       in_if,
  ffbs_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffbs_pkg::APB_AW-1:0]   paddr,
  input  logic [ffbs_pkg::APB_DW-1:0]   pwdata,
  output logic [ffbs_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import ffbs_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  ffbs_cfg_t    cfg;
  ffbs_bcast_t  bcast;

  logic [CW-1:0]          count_r, count_nxt;
  logic                   busy_r, busy_nxt;
  logic                   op_r;
  ffbs_status_t           enq_st_r;
  logic                   out_valid_r, out_valid_nxt;
  ffbs_status_t           out_st_r;
  logic [TAG_W-1:0]       out_tag_r;
  logic [BURST_W-1:0]     out_burst_r;

  logic                   in_fire, enq_go, done, take;
  logic [QUEUE_DEPTH-1:0] hit, lowest, below_pick, shift_en, load_en;
  logic [TAG_W-1:0]       cell_tag   [QUEUE_DEPTH];
  logic [BURST_W-1:0]     cell_burst [QUEUE_DEPTH];
  logic [TAG_W-1:0]       pick_tag;
  logic [BURST_W-1:0]     pick_burst;

  ffbs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_if.ready = !busy_r;
  assign in_fire     = in_if.valid && !busy_r;
  assign enq_go      = in_fire && (in_if.opcode == OP_ENQUEUE) && (count_r != DEPTH_C);
  assign done        = busy_r && (!out_valid_r || out_if.ready);
  assign take        = done && (op_r == OP_SELECT) && (|hit);

  assign bcast.eval       = in_fire && (in_if.opcode == OP_SELECT);
  assign bcast.exec_total = in_if.executing_total;
  assign bcast.capacity   = cfg.capacity;
  assign bcast.window     = cfg.window;

  // lowest set hit, and the cells below it which stay put
  assign below_pick = (hit - QUEUE_DEPTH'(1)) & ~hit;
  assign lowest     = hit & ~(hit - QUEUE_DEPTH'(1));
  assign shift_en   = {QUEUE_DEPTH{take}} & ~below_pick;

  generate
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [TAG_W-1:0]   up_tag;
      logic [BURST_W-1:0] up_burst;

      assign load_en[i] = enq_go && (count_r == CW'(i));

      if (i == QUEUE_DEPTH - 1) begin : g_last
        assign up_tag   = cell_tag[i];
        assign up_burst = cell_burst[i];
      end else begin : g_mid
        assign up_tag   = cell_tag[i+1];
        assign up_burst = cell_burst[i+1];
      end

      ffbs_cell #(
        .IDX (i),
        .CW  (CW)
      ) u_cell (
        .clk        (clk),
        .load_en    (load_en[i]),
        .load_tag   (in_if.req_tag),
        .load_burst (in_if.req_burst),
        .shift_en   (shift_en[i]),
        .nxt_tag    (up_tag),
        .nxt_burst  (up_burst),
        .bcast      (bcast),
        .count      (count_r),
        .tag        (cell_tag[i]),
        .burst      (cell_burst[i]),
        .hit        (hit[i])
      );
    end
  endgenerate

  always_comb begin
    pick_tag   = '0;
    pick_burst = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      pick_tag   = pick_tag | (cell_tag[i] & {TAG_W{lowest[i]}});
      pick_burst = pick_burst | (cell_burst[i] & {BURST_W{lowest[i]}});
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (enq_go) begin
      count_nxt = count_r + CW'(1);
    end else if (take) begin
      count_nxt = count_r - CW'(1);
    end
    busy_nxt = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_if.opcode;
      enq_st_r <= (count_r == DEPTH_C) ? ST_FULL : ST_ENQUEUED;
    end
    if (done) begin
      if (op_r == OP_ENQUEUE) begin
        out_st_r <= enq_st_r;
      end else begin
        out_st_r <= (|hit) ? ST_SELECTED : ST_NONE;
      end
      out_tag_r   <= take ? pick_tag : '0;
      out_burst_r <= take ? pick_burst : '0;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_st_r;
  assign out_if.sel_tag   = out_tag_r;
  assign out_if.sel_burst = out_burst_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue count beyond depth");

  a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> count_r == $past(count_r) - CW'(1))
    else $error("selection did not remove an entry");

  a_onehot_pick: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> $onehot0(lowest))
    else $error("more than one cell picked");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_fire)
    else $error("word accepted while busy");

  a_zero_unsel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_SELECTED) |-> (out_tag_r == '0 && out_burst_r == '0))
    else $error("payload not zero on unselected result");
`endif

endmodule

// File: dv/tb_first_fit_burst_scheduler.sv
`timescale 1ns / 100ps
// Self-checking testbench for first_fit_burst_scheduler: drives request words,
// predicts each status word from a shadow queue and register copy, checks results.
// Depends on ffbs_pkg, ffbs_if and the scheduler RTL.
module tb_first_fit_burst_scheduler;
  import ffbs_pkg::*;

  localparam int DEPTH       = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_LONG   = 150;
  localparam logic [CAP_W-1:0] CAP_UNLIMITED = '1;
  localparam logic [CAP_W-1:0] CAP_MOST_NEG  = 25'h100_0000;
  localparam logic [CAP_W-1:0] CAP_MAX       = 25'h0FF_FFFF;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [BURST_W-1:0] burst;
  } request_t;

  typedef struct packed {
    ffbs_status_t       status;
    logic [TAG_W-1:0]   tag;
    logic [BURST_W-1:0] burst;
  } outcome_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ffbs_in_if  in_ch ();
  ffbs_out_if out_ch ();

  first_fit_burst_scheduler #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block: waiting requests, oldest first, and register copies
  request_t         waiting_q[$];
  outcome_t         outcome_q[$];
  logic [CAP_W-1:0] capacity_m;
  logic [WIN_W-1:0] window_m;

  int mismatches;
  int hold_cycles;
  bit gaps_on;
  bit stalls_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic outcome_t schedule_word(logic op, logic [TAG_W-1:0] tag,
                                             logic [BURST_W-1:0] burst,
                                             logic [TOTAL_W-1:0] total);
    outcome_t res;
    int       pick;
    int       misses;
    res    = '{status: ST_NONE, tag: '0, burst: '0};
    pick   = -1;
    misses = 0;
    if (op == OP_ENQUEUE) begin
      if (waiting_q.size() >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        waiting_q.push_back('{tag: tag, burst: burst});
        res.status = ST_ENQUEUED;
      end
    end else begin
      if (waiting_q.size() != 0 && capacity_m[CAP_W-1]) begin
        pick = 0;
      end else begin
        // head counts as the first miss; sum is 25 bits so it cannot wrap
        for (int i = 0; i < waiting_q.size(); i++) begin
          if ({9'd0, waiting_q[i].burst} + {1'b0, total} <= {1'b0, capacity_m[23:0]}) begin
            pick = i;
            break;
          end
          if (window_m != 0) begin
            misses++;
            if (misses >= window_m) break;
          end
        end
      end
      if (pick >= 0) begin
        res.status = ST_SELECTED;
        res.tag    = waiting_q[pick].tag;
        res.burst  = waiting_q[pick].burst;
        waiting_q.delete(pick);
      end
    end
    return res;
  endfunction

  task automatic send_word(input logic op, input logic [TAG_W-1:0] tag,
                           input logic [BURST_W-1:0] burst,
                           input logic [TOTAL_W-1:0] total);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.opcode          <= op;
    in_ch.req_tag         <= tag;
    in_ch.req_burst       <= burst;
    in_ch.executing_total <= total;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    outcome_q.push_back(schedule_word(op, tag, burst, total));
  endtask

  task automatic send_random(input int enq_pct);
    logic               op;
    logic [BURST_W-1:0] burst;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] room;
    op    = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_SELECT;
    burst = ($urandom_range(0, 3) == 0) ? BURST_W'($urandom_range(0, 255)) :
                                          BURST_W'($urandom_range(0, 65535));
    // mostly keep the total just under the capacity so fits are a toss-up
    if (capacity_m[CAP_W-1] || $urandom_range(0, 3) == 0) begin
      total = TOTAL_W'($urandom_range(0, 24'hFF_FFFF));
    end else begin
      room  = TOTAL_W'($urandom_range(0, 65535));
      total = (capacity_m[23:0] > room) ? capacity_m[23:0] - room : '0;
    end
    send_word(op, TAG_W'($urandom_range(0, 65535)), burst, total);
  endtask

  // let every result come home before touching a register
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_CAPACITY) capacity_m = value[CAP_W-1:0];
    else window_m = value[WIN_W-1:0];
  endtask

  task automatic set_policy(input logic [CAP_W-1:0] cap, input logic [WIN_W-1:0] win);
    write_register(REG_CAPACITY, APB_DW'(cap));
    write_register(REG_WINDOW, APB_DW'(win));
  endtask

  task automatic test_directed();
    // defaults after reset: unlimited capacity, whole queue searched
    send_word(OP_SELECT, 16'h0000, 16'h0000, 24'h00_0000);   // empty queue
    send_word(OP_ENQUEUE, 16'h0000, 16'h0000, 24'hFF_FFFF);
    send_word(OP_ENQUEUE, 16'hFFFF, 16'hFFFF, 24'h00_0000);
    send_word(OP_ENQUEUE, 16'h1234, 16'h8000, 24'h00_0000);
    send_word(OP_SELECT, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF);   // unlimited takes head
    drain();
    set_policy(25'd100, 7'd0);
    send_word(OP_ENQUEUE, 16'h00A1, 16'd200, 24'h0);
    send_word(OP_ENQUEUE, 16'h00B2, 16'd50, 24'h0);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'd50);              // deep hit, exact fit
    drain();
    set_policy(25'd100, 7'd2);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'd0);               // window runs out
    drain();
    set_policy(25'd100, 7'd64);
    send_word(OP_ENQUEUE, 16'h00C3, 16'd100, 24'h0);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'd0);               // window past the tail
    drain();
    set_policy(CAP_MAX, 7'd1);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'hFF_FFFF);         // sum beyond 24 bits
    send_word(OP_SELECT, 16'h0, 16'h0, 24'd0);
    drain();
    set_policy(25'd0, 7'd1);
    send_word(OP_ENQUEUE, 16'h00D4, 16'd0, 24'h0);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'd0);
    drain();
    set_policy(25'd0, 7'd0);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'd0);               // zero burst at zero cap
    send_word(OP_SELECT, 16'h0, 16'h0, 24'd1);
    drain();
    set_policy(CAP_MOST_NEG, 7'd0);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'hFF_FFFF);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'hFF_FFFF);
    send_word(OP_SELECT, 16'h0, 16'h0, 24'h0);
    drain();
  endtask

  task automatic test_queue_full();
    set_policy(CAP_UNLIMITED, 7'd64);
    repeat (DEPTH + 2) begin
      send_word(OP_ENQUEUE, TAG_W'($urandom_range(0, 65535)),
                BURST_W'($urandom_range(0, 65535)),
                TOTAL_W'($urandom_range(0, 24'hFF_FFFF)));
    end
    repeat (DEPTH + 1) begin
      send_word(OP_SELECT, 16'h0, 16'h0, TOTAL_W'($urandom_range(0, 24'hFF_FFFF)));
    end
    drain();
  endtask

  task automatic test_backpressure();
    set_policy(25'd40000, 7'd3);
    hold_cycles = HOLD_LONG;
    repeat (40) send_random(55);
    drain();
  endtask

  task automatic test_random();
    logic [CAP_W-1:0] caps[8];
    logic [WIN_W-1:0] wins[8];
    int               enq_pct[8];
    caps = '{CAP_UNLIMITED, 25'd0, CAP_MAX, 25'($urandom_range(0, 24'hFF_FFFF)),
             25'($urandom_range(0, 300000)), CAP_MOST_NEG, 25'($urandom_range(0, 70000)),
             25'($urandom_range(0, 24'hFF_FFFF))};
    wins = '{7'd0, 7'd1, 7'd64, 7'($urandom_range(0, 64)), 7'd2,
             7'($urandom_range(0, 64)), 7'd0, 7'($urandom_range(0, 64))};
    enq_pct = '{50, 60, 45, 55, 70, 40, 50, 55};
    for (int p = 0; p < 8; p++) begin
      set_policy(caps[p], wins[p]);
      if (p == 7) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      repeat (90) send_random(enq_pct[p]);
      drain();
    end
  endtask

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n           = hold_cycles;
        hold_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected no word, got status %0d tag %h burst %h", $time,
                 out_ch.status, out_ch.sel_tag, out_ch.sel_burst);
      end else begin
        want = outcome_q.pop_front();
        if (out_ch.status !== want.status || out_ch.sel_tag !== want.tag ||
            out_ch.sel_burst !== want.burst) begin
          mismatches++;
          $display("%0t: expected status %0d tag %h burst %h, got status %0d tag %h burst %h",
                   $time, want.status, want.tag, want.burst,
                   out_ch.status, out_ch.sel_tag, out_ch.sel_burst);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : sequencer
    in_ch.valid           <= 1'b0;
    in_ch.opcode          <= OP_ENQUEUE;
    in_ch.req_tag         <= '0;
    in_ch.req_burst       <= '0;
    in_ch.executing_total <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    rst_n                 <= 1'b0;
    capacity_m  = CAP_UNLIMITED;
    window_m    = '0;
    mismatches  = 0;
    hold_cycles = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_queue_full();
    test_backpressure();
    test_random();
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
